### rtl/spvt_pkg.sv
package spvt_pkg;

  localparam int unsigned MaxPairs  = 4096;
  localparam int unsigned MaxValues = 256;
  localparam int unsigned PatchBits = 16;

  localparam logic [15:0] OneQ15 = 16'h8000;

  typedef enum logic [1:0] {
    CmdAdd      = 2'd0,
    CmdFinalize = 2'd1,
    CmdLookup   = 2'd2,
    CmdClear    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StPairFull  = 2'd1,
    StValueFull = 2'd2,
    StPhase     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] first_patch;
    logic [15:0] second_patch;
    logic [15:0] trans_r;
    logic [15:0] trans_g;
    logic [15:0] trans_b;
    logic [13:0] cursor;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_r;
    logic [15:0] out_g;
    logic [15:0] out_b;
    logic [13:0] next_cursor;
    logic        found;
    logic [1:0]  status;
  } out_word_t;

endpackage

### rtl/sparse_pair_value_table.sv
// Sparse symmetric pair table: maps a pair of patch indices to an RGB
// transparency held in a deduplicated colour dictionary.
//
// Input channel: drive start_i high with a command word on in_i; the word is
// taken at an edge where busy_o is low, and busy_o rises straight after it.
// Output channel: every command gives exactly one result word on out_o, shown
// for one cycle with done_o high. The receiver cannot stall, so done_o simply
// pulses; the next word may be taken at the edge that ends that cycle.
//
// Add walks the dictionary entry by entry; finalize mirrors every pair, then
// insertion-sorts all entries; lookup scans from the cursor and stops past the
// end, on a miss or on a hit. One word is in flight at a time, so a new word
// is not taken before the result of the last is shown. One pair RAM, one
// dictionary RAM and one pair comparator serve all commands.
// Reset clears the pair count and the finalize flag and sets the dictionary
// count to 1; entry 0 of the dictionary always reads as 1.0 and is never
// written, so no clearing sweep is needed.
module sparse_pair_value_table #(
  parameter int unsigned MAX_PAIRS  = spvt_pkg::MaxPairs,
  parameter int unsigned MAX_VALUES = spvt_pkg::MaxValues,
  parameter int unsigned PATCH_BITS = spvt_pkg::PatchBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  spvt_pkg::in_word_t   in_i,
  output logic                 busy_o,
  output logic                 done_o,
  output spvt_pkg::out_word_t  out_o
);

  localparam int unsigned Depth = 2 * MAX_PAIRS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = (AW + 1 > 14) ? AW + 1 : 14;
  localparam int unsigned VW    = $clog2(MAX_VALUES);
  localparam int unsigned VCW   = VW + 1;
  localparam int unsigned PB    = (PATCH_BITS < 16) ? PATCH_BITS : 16;

  typedef struct packed {
    logic [PB-1:0]  pa;
    logic [PB-1:0]  pb;
    logic [VW-1:0]  vi;
  } entry_t;

  typedef enum logic [3:0] {
    SIdle, SAddRd, SAddCmp, SAddWr, SMirRd, SMirWr, SSortLd, SSortGet,
    SSortRd, SSortCmp, SLkRd, SLkCmp, SLkVal, SDone
  } state_e;

  // memories
  entry_t       pmem [Depth];
  logic [47:0]  vmem [MAX_VALUES];
  entry_t       prd_q;
  logic [47:0]  vrd_q;
  logic         v0_q;   // last dictionary read was entry 0
  logic [AW-1:0] pra, pwa;
  logic          pwe;
  entry_t        pwd;
  logic [VW-1:0] vra, vwa;
  logic          vwe;

  state_e         state_q;
  spvt_pkg::in_word_t req_q;
  spvt_pkg::out_word_t res_q;
  logic           done_q;
  logic [CW-1:0]  pcnt_q;
  logic [VCW-1:0] vcnt_q;
  logic           fin_q;
  logic [CW-1:0]  i_q, j_q;
  logic [VCW-1:0] k_q;
  entry_t         t_q;

  logic [PB-1:0] key_a, key_b;
  logic [47:0]   rgb;
  assign key_a = req_q.first_patch[PB-1:0];
  assign key_b = req_q.second_patch[PB-1:0];
  assign rgb   = {req_q.trans_r, req_q.trans_g, req_q.trans_b};

  // shared compare unit: x against y by (pa,pb)
  entry_t cx, cy;
  logic   c_lt, c_eq;
  always_comb begin
    c_eq = (cx.pa == cy.pa) && (cx.pb == cy.pb);
    c_lt = (cx.pa < cy.pa) || ((cx.pa == cy.pa) && (cx.pb < cy.pb));
  end

  logic [47:0] vdata;
  assign vdata = v0_q ? {spvt_pkg::OneQ15, spvt_pkg::OneQ15, spvt_pkg::OneQ15} : vrd_q;

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pmem[pwa] <= pwd;
    end
    prd_q <= pmem[pra];
    if (vwe) begin
      vmem[vwa] <= rgb;
    end
    vrd_q <= vmem[vra];
  end

  logic v0_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_rd_q <= 1'b0;
    end else begin
      v0_rd_q <= (vra == '0);
    end
  end
  assign v0_q = v0_rd_q;

  // port addressing per state
  always_comb begin
    pra = '0; pwa = '0; pwe = 1'b0; pwd = t_q;
    vra = '0; vwa = vcnt_q[VW-1:0]; vwe = 1'b0;
    cx = t_q; cy = prd_q;
    unique case (state_q)
      SAddRd:   vra = k_q[VW-1:0];
      SAddWr: begin
        pwe = 1'b1; pwa = pcnt_q[AW-1:0];
        pwd = '{pa: key_a, pb: key_b, vi: k_q[VW-1:0]};
        vwe = (k_q == vcnt_q);
      end
      SMirRd:   pra = i_q[AW-1:0];
      SMirWr: begin
        pwe = 1'b1; pwa = AW'(pcnt_q + i_q);
        pwd = prd_q;
      end
      SSortLd:  pra = i_q[AW-1:0];
      SSortRd:  pra = AW'(j_q - 1'b1);
      SSortCmp: begin
        pwe = 1'b1;
        pwa = j_q[AW-1:0];
        pwd = ((j_q != '0) && c_lt) ? prd_q : t_q;
      end
      SLkRd:    pra = i_q[AW-1:0];
      SLkCmp: begin
        cx = prd_q; cy = '{pa: key_a, pb: key_b, vi: '0};
        vra = prd_q.vi;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      done_q   <= 1'b0;
      pcnt_q   <= '0;
      vcnt_q   <= VCW'(1);
      fin_q    <= 1'b0;
      req_q    <= '0;
      res_q    <= '0;
      t_q      <= '0;
      i_q <= '0; j_q <= '0; k_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (start_i) begin
            req_q <= in_i;
            res_q.out_r <= spvt_pkg::OneQ15;
            res_q.out_g <= spvt_pkg::OneQ15;
            res_q.out_b <= spvt_pkg::OneQ15;
            res_q.found <= 1'b0;
            k_q <= '0;
            unique case (spvt_pkg::cmd_e'(in_i.command))
              spvt_pkg::CmdAdd: begin
                res_q.next_cursor <= '0;
                if (fin_q) begin
                  res_q.status <= spvt_pkg::StPhase; state_q <= SDone;
                end else if (pcnt_q >= CW'(MAX_PAIRS)) begin
                  res_q.status <= spvt_pkg::StPairFull; state_q <= SDone;
                end else begin
                  res_q.status <= spvt_pkg::StOk; state_q <= SAddRd;
                end
              end
              spvt_pkg::CmdFinalize: begin
                res_q.next_cursor <= '0;
                i_q <= '0;
                if (fin_q) begin
                  res_q.status <= spvt_pkg::StPhase; state_q <= SDone;
                end else begin
                  res_q.status <= spvt_pkg::StOk;
                  fin_q <= 1'b1;
                  state_q <= (pcnt_q == '0) ? SDone : SMirRd;
                end
              end
              spvt_pkg::CmdLookup: begin
                if (!fin_q) begin
                  res_q.status <= spvt_pkg::StPhase;
                  res_q.next_cursor <= in_i.cursor;
                  state_q <= SDone;
                end else begin
                  res_q.status <= spvt_pkg::StOk;
                  res_q.next_cursor <= '0;
                  i_q <= CW'(in_i.cursor);
                  state_q <= SLkRd;
                end
              end
              spvt_pkg::CmdClear: begin
                res_q.status <= spvt_pkg::StOk;
                res_q.next_cursor <= '0;
                pcnt_q <= '0; vcnt_q <= VCW'(1); fin_q <= 1'b0;
                state_q <= SDone;
              end
              default: begin
                res_q.status <= spvt_pkg::StOk;
                res_q.next_cursor <= '0;
                state_q <= SDone;
              end
            endcase
          end
        end
        // dictionary walk
        SAddRd: begin
          if (k_q == vcnt_q) begin
            if (vcnt_q >= VCW'(MAX_VALUES)) begin
              res_q.status <= spvt_pkg::StValueFull; state_q <= SDone;
            end else begin
              state_q <= SAddWr;
            end
          end else begin
            state_q <= SAddCmp;
          end
        end
        SAddCmp: begin
          if (vdata == rgb) state_q <= SAddWr;
          else begin
            k_q <= k_q + 1'b1; state_q <= SAddRd;
          end
        end
        SAddWr: begin
          pcnt_q <= pcnt_q + 1'b1;
          if (k_q == vcnt_q) begin
            vcnt_q <= vcnt_q + 1'b1;
          end
          state_q <= SDone;
        end
        // mirror: copy each original to the upper half
        SMirRd: state_q <= SMirWr;
        SMirWr: begin
          if (i_q + 1'b1 == pcnt_q) begin
            i_q <= '0; state_q <= SSortLd;
          end else begin
            i_q <= i_q + 1'b1; state_q <= SMirRd;
          end
        end
        // insertion sort; lower-half entries are taken swapped, so they become
        // the mirrored copies ahead of the originals
        SSortLd: state_q <= SSortGet;
        SSortGet: begin
          t_q <= (i_q < pcnt_q) ? '{pa: prd_q.pb, pb: prd_q.pa, vi: prd_q.vi}
                                : prd_q;
          j_q <= i_q;
          state_q <= SSortRd;
        end
        SSortRd: state_q <= SSortCmp;
        SSortCmp: begin
          if ((j_q != '0) && c_lt) begin
            j_q <= j_q - 1'b1; state_q <= SSortRd;
          end else if (i_q + 1'b1 >= (pcnt_q << 1)) begin
            pcnt_q <= pcnt_q << 1;
            state_q <= SDone;
          end else begin
            i_q <= i_q + 1'b1;
            state_q <= SSortLd;
          end
        end
        // lookup scan
        SLkRd: begin
          if (i_q >= pcnt_q) begin
            res_q.next_cursor <= 14'(pcnt_q); state_q <= SDone;
          end else begin
            state_q <= SLkCmp;
          end
        end
        SLkCmp: begin
          if (c_lt) begin
            i_q <= i_q + 1'b1; state_q <= SLkRd;
          end else if (c_eq) begin
            res_q.found <= 1'b1;
            res_q.next_cursor <= 14'(i_q + 1'b1);
            state_q <= SLkVal;
          end else begin
            res_q.next_cursor <= 14'(i_q); state_q <= SDone;
          end
        end
        SLkVal: begin
          {res_q.out_r, res_q.out_g, res_q.out_b} <= vdata;
          state_q <= SDone;
        end
        SDone: begin
          done_q <= 1'b1; state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;
  assign out_o  = res_q;

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= VCW'(MAX_VALUES)) else $error("dictionary overrun");
`endif

endmodule

### tb/sparse_pair_value_table_tb.sv
module sparse_pair_value_table_tb;

  localparam int unsigned StallLimit = 400000;
  localparam int unsigned RandomItems = 620;

  typedef struct {
    logic [15:0] pa;
    logic [15:0] pb;
    int unsigned vi;
  } pair_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  spvt_pkg::in_word_t  in_i;
  logic                busy_o;
  logic                done_o;
  spvt_pkg::out_word_t out_o;

  // Predictor state: dictionary and sorted pair list.
  logic [15:0] dict_r [spvt_pkg::MaxValues];
  logic [15:0] dict_g [spvt_pkg::MaxValues];
  logic [15:0] dict_b [spvt_pkg::MaxValues];
  int unsigned dict_count;
  pair_t       pairs [2*spvt_pkg::MaxPairs];
  int unsigned pair_count;
  bit          sealed;

  spvt_pkg::out_word_t pending_q [$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned stall_cnt;
  bit          idle_en;
  logic [13:0] chain_cursor;

  spvt_pkg::in_word_t  dir_word [$];
  bit                  dir_fixed [$];
  spvt_pkg::out_word_t dir_exp [$];

  sparse_pair_value_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (in_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .out_o  (out_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void table_empty();
    dict_r[0] = spvt_pkg::OneQ15;
    dict_g[0] = spvt_pkg::OneQ15;
    dict_b[0] = spvt_pkg::OneQ15;
    dict_count = 1;
    pair_count = 0;
    sealed = 1'b0;
  endfunction

  // Compute the result word of one command and advance the predictor state.
  function automatic spvt_pkg::out_word_t table_step(spvt_pkg::in_word_t w);
    spvt_pkg::out_word_t o;
    int unsigned idx;
    int unsigned n;
    int j;
    pair_t t;
    o.out_r = spvt_pkg::OneQ15;
    o.out_g = spvt_pkg::OneQ15;
    o.out_b = spvt_pkg::OneQ15;
    o.next_cursor = '0;
    o.found = 1'b0;
    o.status = spvt_pkg::StOk;
    case (spvt_pkg::cmd_e'(w.command))
      spvt_pkg::CmdAdd: begin
        if (sealed) begin
          o.status = spvt_pkg::StPhase;
        end else if (pair_count >= spvt_pkg::MaxPairs) begin
          o.status = spvt_pkg::StPairFull;
        end else begin
          idx = dict_count;
          for (int i = 0; i < dict_count; i++) begin
            if (dict_r[i] == w.trans_r && dict_g[i] == w.trans_g &&
                dict_b[i] == w.trans_b) begin
              idx = i;
              break;
            end
          end
          if (idx == dict_count) begin
            if (dict_count >= spvt_pkg::MaxValues) begin
              o.status = spvt_pkg::StValueFull;
            end else begin
              dict_r[idx] = w.trans_r;
              dict_g[idx] = w.trans_g;
              dict_b[idx] = w.trans_b;
              dict_count++;
            end
          end
          if (o.status == spvt_pkg::StOk) begin
            pairs[pair_count] = '{w.first_patch, w.second_patch, idx};
            pair_count++;
          end
        end
      end
      spvt_pkg::CmdFinalize: begin
        if (sealed) begin
          o.status = spvt_pkg::StPhase;
        end else begin
          // Mirror: swapped copies first, originals after, then stable sort.
          n = pair_count;
          for (int i = 0; i < n; i++) begin
            pairs[n+i] = pairs[i];
            pairs[i] = '{pairs[n+i].pb, pairs[n+i].pa, pairs[n+i].vi};
          end
          pair_count = 2 * n;
          for (int i = 1; i < pair_count; i++) begin
            t = pairs[i];
            j = i;
            while (j > 0 && (t.pa < pairs[j-1].pa ||
                             (t.pa == pairs[j-1].pa && t.pb < pairs[j-1].pb))) begin
              pairs[j] = pairs[j-1];
              j--;
            end
            pairs[j] = t;
          end
          sealed = 1'b1;
        end
      end
      spvt_pkg::CmdLookup: begin
        if (!sealed) begin
          o.status = spvt_pkg::StPhase;
          o.next_cursor = w.cursor;
        end else begin
          o.next_cursor = 14'(pair_count);
          for (int i = w.cursor; i < pair_count; i++) begin
            if (pairs[i].pa < w.first_patch ||
                (pairs[i].pa == w.first_patch && pairs[i].pb < w.second_patch))
              continue;
            if (pairs[i].pa == w.first_patch && pairs[i].pb == w.second_patch) begin
              o.out_r = dict_r[pairs[i].vi];
              o.out_g = dict_g[pairs[i].vi];
              o.out_b = dict_b[pairs[i].vi];
              o.found = 1'b1;
              o.next_cursor = 14'(i + 1);
            end else begin
              o.next_cursor = 14'(i);
            end
            break;
          end
        end
      end
      spvt_pkg::CmdClear: table_empty();
      default: ;
    endcase
    return o;
  endfunction

  function automatic spvt_pkg::in_word_t mk(spvt_pkg::cmd_e c, logic [15:0] a,
                                            logic [15:0] b, logic [15:0] r,
                                            logic [15:0] g, logic [15:0] bl,
                                            logic [13:0] cur);
    spvt_pkg::in_word_t w;
    w.command = c;
    w.first_patch = a;
    w.second_patch = b;
    w.trans_r = r;
    w.trans_g = g;
    w.trans_b = bl;
    w.cursor = cur;
    return w;
  endfunction

  function automatic spvt_pkg::out_word_t rs(logic [15:0] r, logic [15:0] g,
                                             logic [15:0] b, logic [13:0] nc,
                                             logic f, spvt_pkg::status_e s);
    spvt_pkg::out_word_t o;
    o.out_r = r;
    o.out_g = g;
    o.out_b = b;
    o.next_cursor = nc;
    o.found = f;
    o.status = s;
    return o;
  endfunction

  // Result word of a command that returns no colour.
  function automatic spvt_pkg::out_word_t miss(logic [13:0] nc, spvt_pkg::status_e s);
    return rs(spvt_pkg::OneQ15, spvt_pkg::OneQ15, spvt_pkg::OneQ15, nc, 1'b0, s);
  endfunction

  function automatic void row(spvt_pkg::in_word_t w, bit fixed, spvt_pkg::out_word_t e);
    dir_word.push_back(w);
    dir_fixed.push_back(fixed);
    dir_exp.push_back(e);
  endfunction

  // Hold the word on the port until taken, then queue what it should return.
  task automatic send_word(spvt_pkg::in_word_t w, bit fixed = 1'b0,
                           spvt_pkg::out_word_t fx = '0);
    spvt_pkg::out_word_t p;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    p = table_step(w);
    pending_q.push_back(fixed ? fx : p);
    chain_cursor = p.next_cursor;
    items_sent++;
  endtask

  function automatic logic [15:0] pick_patch();
    return ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
  endfunction

  // One clear / fill / finalize / scan cycle with a little noise mixed in.
  task automatic run_session();
    logic [15:0] pool [4];
    int unsigned k;
    int unsigned pc;
    logic [13:0] cur;
    int unsigned sel;
    for (int i = 0; i < 4; i++) pool[i] = 16'($urandom);
    if ($urandom_range(0, 9) != 0)
      send_word(mk(spvt_pkg::CmdClear, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 14'($urandom)));
    k = $urandom_range(0, 12);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(spvt_pkg::in_word_t'({$urandom, $urandom, $urandom}));
        if (pair_count > 30) send_word(mk(spvt_pkg::CmdClear, 0, 0, 0, 0, 0, 0));
      end
      pc = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0)
        send_word(mk(spvt_pkg::CmdAdd, pick_patch(), pick_patch(), 16'($urandom),
                     16'($urandom), 16'($urandom), 14'($urandom)));
      else
        send_word(mk(spvt_pkg::CmdAdd, pick_patch(), pick_patch(), pool[pc],
                     pool[(pc+1)%4], pool[(pc+2)%4], 14'($urandom)));
    end
    send_word(mk(spvt_pkg::CmdFinalize, 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 14'($urandom)));
    chain_cursor = '0;
    k = $urandom_range(1, 15);
    for (int i = 0; i < k; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) cur = chain_cursor;
      else if (sel < 7) cur = '0;
      else if (sel < 9) cur = 14'($urandom_range(0, pair_count + 2));
      else cur = 14'($urandom);
      send_word(mk(spvt_pkg::CmdLookup, pick_patch(), pick_patch(), 16'($urandom),
                   16'($urandom), 16'($urandom), cur));
    end
  endtask

  // Compare every result word with the oldest pending one.
  always @(posedge clk_i) begin
    spvt_pkg::out_word_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_o);
      end else begin
        e = pending_q.pop_front();
        if (out_o.out_r !== e.out_r || out_o.out_g !== e.out_g ||
            out_o.out_b !== e.out_b || out_o.next_cursor !== e.next_cursor ||
            out_o.found !== e.found || out_o.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp r=%h g=%h b=%h nc=%0d f=%b st=%0d, ",
                      "got r=%h g=%h b=%h nc=%0d f=%b st=%0d"},
                     e.out_r, e.out_g, e.out_b, e.next_cursor, e.found, e.status,
                     out_o.out_r, out_o.out_g, out_o.out_b, out_o.next_cursor,
                     out_o.found, out_o.status);
        end
      end
    end
  end

  // Watchdog: advance on cycles with no word taken and no result shown.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    spvt_pkg::out_word_t dflt;
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    mismatches = 0;
    items_sent = 0;
    stall_cnt = 0;
    idle_en = 1'b1;
    chain_cursor = '0;
    table_empty();
    dflt = miss(0, spvt_pkg::StOk);

    // Directed rows: typed expectations where obvious, predictor elsewhere.
    row(mk(spvt_pkg::CmdLookup, 0, 0, 0, 0, 0, 14'h3FFF), 1,
        miss(14'h3FFF, spvt_pkg::StPhase));
    row(mk(spvt_pkg::CmdAdd, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF),
        1, dflt);
    row(mk(spvt_pkg::CmdAdd, 0, 0, spvt_pkg::OneQ15, spvt_pkg::OneQ15, spvt_pkg::OneQ15,
           0), 1, dflt);
    row(mk(spvt_pkg::CmdAdd, 0, 16'hFFFF, 0, 0, 0, 0), 1, dflt);
    row(mk(spvt_pkg::CmdAdd, 1, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 0, dflt);
    row(mk(spvt_pkg::CmdAdd, 2, 1, 1, 2, 3, 0), 0, dflt);
    row(mk(spvt_pkg::CmdAdd, 1, 2, 4, 5, 6, 0), 0, dflt);
    row(mk(spvt_pkg::CmdFinalize, 0, 0, 0, 0, 0, 0), 0, dflt);
    row(mk(spvt_pkg::CmdFinalize, 0, 0, 0, 0, 0, 0), 1, miss(0, spvt_pkg::StPhase));
    row(mk(spvt_pkg::CmdAdd, 3, 3, 7, 7, 7, 0), 1, miss(0, spvt_pkg::StPhase));
    row(mk(spvt_pkg::CmdLookup, 0, 0, 0, 0, 0, 0), 0, dflt);
    row(mk(spvt_pkg::CmdLookup, 1, 2, 0, 0, 0, 0), 0, dflt);
    row(mk(spvt_pkg::CmdLookup, 1, 2, 0, 0, 0, 3), 0, dflt);
    row(mk(spvt_pkg::CmdLookup, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0), 0, dflt);
    row(mk(spvt_pkg::CmdLookup, 16'hFFFF, 0, 0, 0, 0, 0), 0, dflt);
    row(mk(spvt_pkg::CmdLookup, 0, 16'hFFFF, 0, 0, 0, 14'h3FFF), 1,
        miss(12, spvt_pkg::StOk));
    row(mk(spvt_pkg::CmdLookup, 5, 5, 0, 0, 0, 0), 0, dflt);
    row(mk(spvt_pkg::CmdClear, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF),
        1, dflt);
    row(mk(spvt_pkg::CmdFinalize, 0, 0, 0, 0, 0, 0), 1, dflt);
    row(mk(spvt_pkg::CmdLookup, 0, 0, 0, 0, 0, 0), 1, miss(0, spvt_pkg::StOk));
    row(mk(spvt_pkg::CmdClear, 0, 0, 0, 0, 0, 0), 1, dflt);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < dir_word.size(); i++) send_word(dir_word[i], dir_fixed[i], dir_exp[i]);

    while (items_sent < RandomItems) run_session();

    // Fill the dictionary past its last entry, then reuse a stored colour.
    send_word(mk(spvt_pkg::CmdClear, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < spvt_pkg::MaxValues + 2; i++)
      send_word(mk(spvt_pkg::CmdAdd, 16'(i), 16'(i), 16'(i), 16'hA5A5, 16'($urandom), 0));
    send_word(mk(spvt_pkg::CmdAdd, 9, 9, spvt_pkg::OneQ15, spvt_pkg::OneQ15,
                 spvt_pkg::OneQ15, 0));
    send_word(mk(spvt_pkg::CmdClear, 0, 0, 0, 0, 0, 0));

    // Lookup before finalize, then start afresh.
    send_word(mk(spvt_pkg::CmdAdd, 1, 1, 16'h1234, 16'h5678, 16'h9ABC, 0));
    send_word(mk(spvt_pkg::CmdLookup, 1, 1, 0, 0, 0, 14'($urandom)));
    send_word(mk(spvt_pkg::CmdClear, 0, 0, 0, 0, 0, 0));
    send_word(mk(spvt_pkg::CmdAdd, 1, 1, 16'h1234, 16'h5678, 16'h9ABC, 0));

    // Drop all idling for the tail.
    idle_en = 1'b0;
    for (int i = 0; i < 10; i++) run_session();

    @(posedge clk_i);
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
